// ===== rtl/core/aae_pkg.sv =====
// ----------------------------------------------------------------------------
// aae_pkg: shared constants, types and helpers of the attitude angle error core
// Fixed-point limits, register indexes, job codes and the arctangent table.
// ----------------------------------------------------------------------------
package aae_pkg;

    localparam int COMPONENT_BITS_DEF  = 18;
    localparam int ANGLE_FRAC_BITS_DEF = 8;

    localparam int VEC_W        = 21;   // prescaled component, under 2^20
    localparam int PRE_LIM      = 20;
    localparam int REJ_LIM      = 30;
    localparam int PAIR_LIM     = 30;
    localparam int CORDIC_STEPS = 28;
    localparam int ACC_FRAC     = 24;
    localparam int RAD_W        = 62;   // radicand and root working width
    localparam int SQRT_CELLS   = 31;
    localparam int Z_W          = 34;   // angle accumulator, 2^-24 degree
    localparam int NORM_MSB     = 58;

    localparam longint DEG_PER_RAD_Q24 = 961263669;
    localparam int     TGT_ONE         = 65536;

    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_TGT_FORE_X = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TGT_FORE_Y = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TGT_FORE_Z = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TGT_TOP_X  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TGT_TOP_Y  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_TGT_TOP_Z  = 3'd5;

    localparam logic [1:0] JOB_PITCH = 2'd0;
    localparam logic [1:0] JOB_YAW   = 2'd1;
    localparam logic [1:0] JOB_ROLL  = 2'd2;

    typedef struct packed {
        logic [1:0] job;
        logic       degen;
        logic       neg;
    } t_tag;

    typedef struct packed {
        logic signed [PAIR_LIM:0] d;
        t_tag                     tag;
    } t_sq_side;

    typedef struct packed {
        logic base;
        t_tag tag;
    } t_cd_side;

    // atan(2^-i) in degrees, scaled by 2^24
    localparam longint ATAN_HEAD [12] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367
    };

    function automatic logic signed [Z_W-1:0] atan_entry(input int i);
        longint v;
        if (i < 12) begin
            v = ATAN_HEAD[i];
        end else begin
            v = (DEG_PER_RAD_Q24 + (longint'(1) << (i - 1))) >> i;
        end
        return Z_W'(v);
    endfunction

    function automatic logic [63:0] magn64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [5:0] msb64(input logic [63:0] v);
        logic [5:0] idx;
        idx = '0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) idx = 6'(i);
        end
        return idx;
    endfunction

endpackage

// ===== rtl/core/aae_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// aae_sqrt_cell: one bit of the integer square root chain
// Tries one root bit per cell and hands the remainder on.
// ----------------------------------------------------------------------------
module aae_sqrt_cell
    import aae_pkg::*;
#(
    parameter int BIT_POS = 0,
    parameter int SIDE_W  = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [RAD_W-1:0]  i_rem,
    input  logic [RAD_W-1:0]  i_root,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [RAD_W-1:0]  o_rem,
    output logic [RAD_W-1:0]  o_root,
    output logic [SIDE_W-1:0] o_side
);

    localparam logic [RAD_W:0] BIT = (RAD_W+1)'(1) << BIT_POS;

    logic [RAD_W:0]   trial;
    logic             take;
    logic [RAD_W-1:0] n_rem;
    logic [RAD_W-1:0] n_root;

    always_comb begin
        trial = {1'b0, i_root} + BIT;
        take  = ({1'b0, i_rem} >= trial);
        if (take) begin
            n_rem  = RAD_W'({1'b0, i_rem} - trial);
            n_root = RAD_W'({1'b0, i_root >> 1} + BIT);
        end else begin
            n_rem  = i_rem;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rem  <= n_rem;
        o_root <= n_root;
        o_side <= i_side;
    end

endmodule

// ===== rtl/core/aae_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// aae_cordic_cell: one vectoring rotation step
// Rotates toward the x axis and accumulates the step angle.
// ----------------------------------------------------------------------------
module aae_cordic_cell
    import aae_pkg::*;
#(
    parameter int IDX    = 0,
    parameter int SIDE_W = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  logic signed [63:0]    i_x,
    input  logic signed [63:0]    i_y,
    input  logic signed [Z_W-1:0] i_z,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_vld,
    output logic signed [63:0]    o_x,
    output logic signed [63:0]    o_y,
    output logic signed [Z_W-1:0] o_z,
    output logic [SIDE_W-1:0]     o_side
);

    localparam logic signed [Z_W-1:0] ANG = atan_entry(IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_side <= i_side;
        if (i_y > 0) begin
            o_x <= i_x + (i_y >>> IDX);
            o_y <= i_y - (i_x >>> IDX);
            o_z <= i_z + ANG;
        end else begin
            o_x <= i_x - (i_y >>> IDX);
            o_y <= i_y + (i_x >>> IDX);
            o_z <= i_z - ANG;
        end
    end

endmodule

// ===== rtl/core/attitude_angle_error_core.sv =====
// ----------------------------------------------------------------------------
// attitude_angle_error_core: pitch, yaw and roll errors from body axes
// Rejects a target vector from one body axis, measures the angle to a second
// axis through a square root chain and a vectoring rotation chain.
// ----------------------------------------------------------------------------
// The three angles share one datapath and enter it in consecutive cycles;
//   o_busy is high while pitch and yaw issue, and a new word can be accepted
//   as roll issues, while earlier words are still in the pipeline.
// o_done is high for one cycle and cannot be held off by the receiver.
// Reset (synchronous, active low) clears the pipeline valids and loads the
//   target registers with fore = +x and top = +z.
// ----------------------------------------------------------------------------
module attitude_angle_error_core
    import aae_pkg::*;
#(
    parameter int COMPONENT_BITS  = COMPONENT_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic                              i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]             i_cfg_addr,
    input  logic [COMPONENT_BITS-1:0]         i_cfg_data,
    input  logic signed [COMPONENT_BITS-1:0]  i_fore_x,
    input  logic signed [COMPONENT_BITS-1:0]  i_fore_y,
    input  logic signed [COMPONENT_BITS-1:0]  i_fore_z,
    input  logic signed [COMPONENT_BITS-1:0]  i_star_x,
    input  logic signed [COMPONENT_BITS-1:0]  i_star_y,
    input  logic signed [COMPONENT_BITS-1:0]  i_star_z,
    input  logic signed [COMPONENT_BITS-1:0]  i_top_x,
    input  logic signed [COMPONENT_BITS-1:0]  i_top_y,
    input  logic signed [COMPONENT_BITS-1:0]  i_top_z,
    output logic                              o_done,
    output logic signed [ANGLE_FRAC_BITS+8:0] o_pitch_error,
    output logic signed [ANGLE_FRAC_BITS+8:0] o_yaw_error,
    output logic signed [ANGLE_FRAC_BITS+8:0] o_roll_error,
    output logic [2:0]                        o_undefined_mask
);

    localparam int CW     = COMPONENT_BITS;
    localparam int OW     = ANGLE_FRAC_BITS + 9;
    localparam int B2_W   = 2 * VEC_W + 2;       // |b|^2 and s.b
    localparam int LO_W   = B2_W / 2;            // low slice of the split product
    localparam int HI_W   = B2_W - LO_W;
    localparam int PL_W   = LO_W + 1 + VEC_W;
    localparam int PH_W   = HI_W + VEC_W;
    localparam int RS_W   = REJ_LIM + 1;         // squeezed rejection
    localparam int PR_W   = VEC_W + RS_W;
    localparam int C_W    = PR_W + 2;            // cross and dot sums
    localparam int PS_W   = PAIR_LIM + 1;
    localparam int Y_W    = 32;
    localparam int SH     = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam longint HALF    = longint'(1) << (SH - 1);
    localparam longint Z_BASE  = longint'(90) << ACC_FRAC;
    localparam longint Z_LIM   = longint'(180) << ACC_FRAC;
    localparam int     MAX_OUT = 180 << ANGLE_FRAC_BITS;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_PITCH = 4'b0010,
        PH_YAW   = 4'b0100,
        PH_ROLL  = 4'b1000
    } t_phase;

    typedef logic signed [VEC_W-1:0] t_vec [3];

    // ---------------------------------------------------------------- helpers
    // Shift amount that brings a vector under 2^20 (floor shift).
    function automatic logic [5:0] pre_k(input logic signed [CW-1:0] a,
                                         input logic signed [CW-1:0] b,
                                         input logic signed [CW-1:0] c);
        logic [63:0] m;
        logic [5:0]  idx;
        m   = magn64(64'(a)) | magn64(64'(b)) | magn64(64'(c));
        idx = msb64(m);
        return (idx >= 6'(PRE_LIM)) ? 6'(idx - 6'(PRE_LIM - 1)) : 6'd0;
    endfunction

    function automatic logic signed [VEC_W-1:0] pre_c(input logic signed [CW-1:0] v,
                                                      input logic [5:0] k);
        logic signed [63:0] w;
        w = 64'(v);
        return VEC_W'(w >>> k);
    endfunction

    // --------------------------------------------------------- configuration
    logic signed [CW-1:0] r_tgt [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt[0] <= CW'(TGT_ONE);
            r_tgt[1] <= '0;
            r_tgt[2] <= '0;
            r_tgt[3] <= '0;
            r_tgt[4] <= '0;
            r_tgt[5] <= CW'(TGT_ONE);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_TGT_FORE_X: r_tgt[0] <= i_cfg_data;
                REG_TGT_FORE_Y: r_tgt[1] <= i_cfg_data;
                REG_TGT_FORE_Z: r_tgt[2] <= i_cfg_data;
                REG_TGT_TOP_X:  r_tgt[3] <= i_cfg_data;
                REG_TGT_TOP_Y:  r_tgt[4] <= i_cfg_data;
                REG_TGT_TOP_Z:  r_tgt[5] <= i_cfg_data;
                default: ;      // drop writes past the register list
            endcase
        end
    end

    // ------------------------------------------------------- accept / issue
    t_phase r_phase;
    t_phase n_phase;
    logic   accept;

    assign o_busy = (r_phase == PH_PITCH) || (r_phase == PH_YAW);
    assign accept = i_start && !o_busy;

    always_comb begin
        case (r_phase)
            PH_PITCH: n_phase = PH_YAW;
            PH_YAW:   n_phase = PH_ROLL;
            PH_IDLE, PH_ROLL: n_phase = accept ? PH_PITCH : PH_IDLE;
            default:  n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    // Prescaled axes and targets, held while the three angles issue.
    t_vec r_p_fore, r_p_star, r_p_top, r_p_sf, r_p_st;
    logic [5:0] k_fore, k_star, k_top, k_sf, k_st;

    assign k_fore = pre_k(i_fore_x, i_fore_y, i_fore_z);
    assign k_star = pre_k(i_star_x, i_star_y, i_star_z);
    assign k_top  = pre_k(i_top_x, i_top_y, i_top_z);
    assign k_sf   = pre_k(r_tgt[0], r_tgt[1], r_tgt[2]);
    assign k_st   = pre_k(r_tgt[3], r_tgt[4], r_tgt[5]);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_fore[0] <= pre_c(i_fore_x, k_fore);
            r_p_fore[1] <= pre_c(i_fore_y, k_fore);
            r_p_fore[2] <= pre_c(i_fore_z, k_fore);
            r_p_star[0] <= pre_c(i_star_x, k_star);
            r_p_star[1] <= pre_c(i_star_y, k_star);
            r_p_star[2] <= pre_c(i_star_z, k_star);
            r_p_top[0]  <= pre_c(i_top_x, k_top);
            r_p_top[1]  <= pre_c(i_top_y, k_top);
            r_p_top[2]  <= pre_c(i_top_z, k_top);
            for (int i = 0; i < 3; i++) begin
                r_p_sf[i] <= pre_c(r_tgt[i], k_sf);
                r_p_st[i] <= pre_c(r_tgt[3+i], k_st);
            end
        end
    end

    // ------------------------------------------------------ front pipeline
    // Valid bits, reset.
    logic r_i_vld, r_m1_vld, r_m2_vld, r_m3_vld, r_m4_vld, r_m5_vld;
    logic r_m6_vld, r_m7_vld, r_m8_vld, r_m9_vld, r_m10_vld, r_m11_vld;
    logic r_v1_vld, r_v2_vld, r_v3_vld, r_f_vld;

    // Tags and data.
    t_tag r_i_tag, r_m1_tag, r_m2_tag, r_m3_tag, r_m4_tag, r_m5_tag;
    t_tag r_m6_tag, r_m7_tag, r_m8_tag, r_m9_tag, r_m10_tag, r_m11_tag;
    t_tag r_v1_tag, r_v2_tag, r_v3_tag, r_f_tag;

    t_vec r_i_s, r_i_b, r_i_a, r_i_t;
    t_vec r_m1_s, r_m1_b, r_m1_a, r_m1_t;
    logic signed [B2_W-1:0] r_m1_b2, r_m1_sb;
    t_vec r_m2_a, r_m2_t;
    logic signed [PL_W-1:0] r_m2_pls [3], r_m2_plb [3];
    logic signed [PH_W-1:0] r_m2_phs [3], r_m2_phb [3];
    t_vec r_m3_a, r_m3_t, r_m4_a, r_m4_t, r_m5_a, r_m5_t;
    logic signed [63:0] r_m3_r [3], r_m4_r [3];
    logic [5:0] r_m4_k;
    logic signed [RS_W-1:0] r_m5_r [3];
    logic signed [PR_W-1:0] r_m6_cp [6], r_m6_dp [3], r_m6_sp [3];
    logic signed [C_W-1:0]  r_m7_c [4], r_m8_c [4];
    logic [5:0] r_m8_k;
    logic signed [PS_W-1:0] r_m9_c [4];
    logic [RAD_W-1:0]       r_m10_sq [3];
    logic signed [PS_W-1:0] r_m10_d, r_m11_d;
    logic [RAD_W-1:0]       r_m11_rad;
    logic [Y_W-1:0]  r_v1_x, r_v1_y, r_v2_x, r_v2_y;
    logic            r_v1_base, r_v2_base, r_v3_base;
    logic [5:0]      r_v2_n;
    logic signed [63:0] r_v3_x, r_v3_y;
    logic signed [OW-1:0] r_f_q;

    // Combinational helpers between stages.
    logic [63:0] m4_or, m8_or;
    logic [5:0]  m4_idx, m8_idx;
    logic signed [C_W:0] m7_sd;
    logic                a_zero;

    always_comb begin
        m4_or = magn64(r_m3_r[0]) | magn64(r_m3_r[1]) | magn64(r_m3_r[2]);
        m4_idx = msb64(m4_or);
        m8_or = magn64(64'(r_m7_c[0])) | magn64(64'(r_m7_c[1]))
              | magn64(64'(r_m7_c[2])) | magn64(64'(r_m7_c[3]));
        m8_idx = msb64(m8_or);
        a_zero = (r_m3_a[0] == '0) && (r_m3_a[1] == '0) && (r_m3_a[2] == '0);
        m7_sd  = (C_W+1)'(r_m6_sp[0]) + (C_W+1)'(r_m6_sp[1]) + (C_W+1)'(r_m6_sp[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_vld  <= 1'b0; r_m1_vld <= 1'b0; r_m2_vld <= 1'b0; r_m3_vld <= 1'b0;
            r_m4_vld <= 1'b0; r_m5_vld <= 1'b0; r_m6_vld <= 1'b0; r_m7_vld <= 1'b0;
            r_m8_vld <= 1'b0; r_m9_vld <= 1'b0; r_m10_vld <= 1'b0; r_m11_vld <= 1'b0;
        end else begin
            r_i_vld   <= (r_phase == PH_PITCH) || (r_phase == PH_YAW)
                      || (r_phase == PH_ROLL);
            r_m1_vld  <= r_i_vld;
            r_m2_vld  <= r_m1_vld;
            r_m3_vld  <= r_m2_vld;
            r_m4_vld  <= r_m3_vld;
            r_m5_vld  <= r_m4_vld;
            r_m6_vld  <= r_m5_vld;
            r_m7_vld  <= r_m6_vld;
            r_m8_vld  <= r_m7_vld;
            r_m9_vld  <= r_m8_vld;
            r_m10_vld <= r_m9_vld;
            r_m11_vld <= r_m10_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        // Issue: pick the vectors of this angle.
        r_i_tag.degen <= 1'b0;
        r_i_tag.neg   <= 1'b0;
        case (r_phase)
            PH_PITCH: begin
                r_i_tag.job <= JOB_PITCH;
                r_i_s <= r_p_sf; r_i_b <= r_p_star; r_i_a <= r_p_fore; r_i_t <= r_p_top;
            end
            PH_YAW: begin
                r_i_tag.job <= JOB_YAW;
                r_i_s <= r_p_sf; r_i_b <= r_p_top; r_i_a <= r_p_fore; r_i_t <= r_p_star;
            end
            default: begin
                r_i_tag.job <= JOB_ROLL;
                r_i_s <= r_p_st; r_i_b <= r_p_fore; r_i_a <= r_p_top; r_i_t <= r_p_star;
            end
        endcase

        // |b|^2 and s.b
        r_m1_tag <= r_i_tag;
        r_m1_s <= r_i_s; r_m1_b <= r_i_b; r_m1_a <= r_i_a; r_m1_t <= r_i_t;
        r_m1_b2 <= B2_W'(r_i_b[0] * r_i_b[0]) + B2_W'(r_i_b[1] * r_i_b[1])
                 + B2_W'(r_i_b[2] * r_i_b[2]);
        r_m1_sb <= B2_W'(r_i_s[0] * r_i_b[0]) + B2_W'(r_i_s[1] * r_i_b[1])
                 + B2_W'(r_i_s[2] * r_i_b[2]);

        // Split products of the rejection.
        r_m2_tag <= r_m1_tag;
        r_m2_a <= r_m1_a; r_m2_t <= r_m1_t;
        for (int i = 0; i < 3; i++) begin
            r_m2_pls[i] <= $signed({1'b0, r_m1_b2[LO_W-1:0]}) * r_m1_s[i];
            r_m2_phs[i] <= $signed(r_m1_b2[B2_W-1:LO_W]) * r_m1_s[i];
            r_m2_plb[i] <= $signed({1'b0, r_m1_sb[LO_W-1:0]}) * r_m1_b[i];
            r_m2_phb[i] <= $signed(r_m1_sb[B2_W-1:LO_W]) * r_m1_b[i];
        end

        // r = |b|^2 s - (s.b) b
        r_m3_tag <= r_m2_tag;
        r_m3_a <= r_m2_a; r_m3_t <= r_m2_t;
        for (int i = 0; i < 3; i++) begin
            r_m3_r[i] <= (64'(r_m2_phs[i]) <<< LO_W) + 64'(r_m2_pls[i])
                       - (64'(r_m2_phb[i]) <<< LO_W) - 64'(r_m2_plb[i]);
        end

        // Flag degenerate angles, find the rejection shift.
        r_m4_tag <= '{job: r_m3_tag.job, degen: a_zero || (m4_or == '0),
                      neg: r_m3_tag.neg};
        r_m4_a <= r_m3_a; r_m4_t <= r_m3_t; r_m4_r <= r_m3_r;
        r_m4_k <= (m4_idx >= 6'(REJ_LIM)) ? 6'(m4_idx - 6'(REJ_LIM - 1)) : 6'd0;

        r_m5_tag <= r_m4_tag;
        r_m5_a <= r_m4_a; r_m5_t <= r_m4_t;
        for (int i = 0; i < 3; i++) r_m5_r[i] <= RS_W'(r_m4_r[i] >>> r_m4_k);

        // Cross, dot and sign products.
        r_m6_tag <= r_m5_tag;
        r_m6_cp[0] <= r_m5_a[1] * r_m5_r[2]; r_m6_cp[1] <= r_m5_a[2] * r_m5_r[1];
        r_m6_cp[2] <= r_m5_a[2] * r_m5_r[0]; r_m6_cp[3] <= r_m5_a[0] * r_m5_r[2];
        r_m6_cp[4] <= r_m5_a[0] * r_m5_r[1]; r_m6_cp[5] <= r_m5_a[1] * r_m5_r[0];
        for (int i = 0; i < 3; i++) begin
            r_m6_dp[i] <= r_m5_a[i] * r_m5_r[i];
            r_m6_sp[i] <= r_m5_t[i] * r_m5_r[i];
        end

        r_m7_tag  <= '{job: r_m6_tag.job, degen: r_m6_tag.degen, neg: m7_sd[C_W]};
        r_m7_c[0] <= C_W'(r_m6_cp[0]) - C_W'(r_m6_cp[1]);
        r_m7_c[1] <= C_W'(r_m6_cp[2]) - C_W'(r_m6_cp[3]);
        r_m7_c[2] <= C_W'(r_m6_cp[4]) - C_W'(r_m6_cp[5]);
        r_m7_c[3] <= C_W'(r_m6_dp[0]) + C_W'(r_m6_dp[1]) + C_W'(r_m6_dp[2]);

        r_m8_tag <= r_m7_tag;
        r_m8_c   <= r_m7_c;
        r_m8_k   <= (m8_idx >= 6'(PAIR_LIM)) ? 6'(m8_idx - 6'(PAIR_LIM - 1)) : 6'd0;

        r_m9_tag <= r_m8_tag;
        for (int i = 0; i < 4; i++) r_m9_c[i] <= PS_W'(r_m8_c[i] >>> r_m8_k);

        r_m10_tag <= r_m9_tag;
        r_m10_d   <= r_m9_c[3];
        for (int i = 0; i < 3; i++) r_m10_sq[i] <= RAD_W'(r_m9_c[i] * r_m9_c[i]);

        r_m11_tag <= r_m10_tag;
        r_m11_d   <= r_m10_d;
        r_m11_rad <= r_m10_sq[0] + r_m10_sq[1] + r_m10_sq[2];
    end

    // ------------------------------------------------------ square root chain
    localparam int SQ_SW = $bits(t_sq_side);

    logic             sq_vld  [SQRT_CELLS+1];
    logic [RAD_W-1:0] sq_rem  [SQRT_CELLS+1];
    logic [RAD_W-1:0] sq_root [SQRT_CELLS+1];
    logic [SQ_SW-1:0] sq_side [SQRT_CELLS+1];
    t_sq_side         sq_in_side, sq_out_side;

    assign sq_in_side.d   = r_m11_d;
    assign sq_in_side.tag = r_m11_tag;
    assign sq_vld[0]  = r_m11_vld;
    assign sq_rem[0]  = r_m11_rad;
    assign sq_root[0] = '0;
    assign sq_side[0] = sq_in_side;

    for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
        aae_sqrt_cell #(
            .BIT_POS (2 * (SQRT_CELLS - 1 - g)),
            .SIDE_W  (SQ_SW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (sq_vld[g]),
            .i_rem  (sq_rem[g]),
            .i_root (sq_root[g]),
            .i_side (sq_side[g]),
            .o_vld  (sq_vld[g+1]),
            .o_rem  (sq_rem[g+1]),
            .o_root (sq_root[g+1]),
            .o_side (sq_side[g+1])
        );
    end

    assign sq_out_side = sq_side[SQRT_CELLS];

    // ---------------------------------------------------- vectoring set-up
    // Fold a negative cosine into the upper quadrant, then normalize so the
    // larger of x, y has its top bit at 2^58.
    logic [5:0] v2_idx;

    assign v2_idx = msb64({32'b0, r_v1_x | r_v1_y});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1_vld <= 1'b0;
            r_v2_vld <= 1'b0;
            r_v3_vld <= 1'b0;
        end else begin
            r_v1_vld <= sq_vld[SQRT_CELLS];
            r_v2_vld <= r_v1_vld;
            r_v3_vld <= r_v2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v1_tag <= sq_out_side.tag;
        if (sq_out_side.d < 0) begin
            r_v1_x    <= sq_root[SQRT_CELLS][Y_W-1:0];
            r_v1_y    <= Y_W'(-64'(sq_out_side.d));
            r_v1_base <= 1'b1;
        end else begin
            r_v1_x    <= Y_W'(64'(sq_out_side.d));
            r_v1_y    <= sq_root[SQRT_CELLS][Y_W-1:0];
            r_v1_base <= 1'b0;
        end

        r_v2_tag  <= r_v1_tag;
        r_v2_base <= r_v1_base;
        r_v2_x    <= r_v1_x;
        r_v2_y    <= r_v1_y;
        r_v2_n    <= 6'(NORM_MSB) - v2_idx;

        r_v3_tag  <= r_v2_tag;
        r_v3_base <= r_v2_base;
        r_v3_x    <= $signed(64'(r_v2_x) << r_v2_n);
        r_v3_y    <= $signed(64'(r_v2_y) << r_v2_n);
    end

    // ---------------------------------------------------------- CORDIC chain
    localparam int CD_SW = $bits(t_cd_side);

    logic                  cd_vld  [CORDIC_STEPS+1];
    logic signed [63:0]    cd_x    [CORDIC_STEPS+1];
    logic signed [63:0]    cd_y    [CORDIC_STEPS+1];
    logic signed [Z_W-1:0] cd_z    [CORDIC_STEPS+1];
    logic [CD_SW-1:0]      cd_side [CORDIC_STEPS+1];
    t_cd_side              cd_in_side, cd_out_side;

    assign cd_in_side.base = r_v3_base;
    assign cd_in_side.tag  = r_v3_tag;
    assign cd_vld[0]  = r_v3_vld;
    assign cd_x[0]    = r_v3_x;
    assign cd_y[0]    = r_v3_y;
    assign cd_z[0]    = '0;
    assign cd_side[0] = cd_in_side;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        aae_cordic_cell #(
            .IDX    (g),
            .SIDE_W (CD_SW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (cd_vld[g]),
            .i_x    (cd_x[g]),
            .i_y    (cd_y[g]),
            .i_z    (cd_z[g]),
            .i_side (cd_side[g]),
            .o_vld  (cd_vld[g+1]),
            .o_x    (cd_x[g+1]),
            .o_y    (cd_y[g+1]),
            .o_z    (cd_z[g+1]),
            .o_side (cd_side[g+1])
        );
    end

    assign cd_out_side = cd_side[CORDIC_STEPS];

    // ------------------------------------------------------------ finishing
    // Add the quadrant base, clamp to [0, 180] degrees, round half up,
    // then apply the sign and the degenerate override.
    logic signed [Z_W:0]  f_zb;
    logic signed [Z_W:0]  f_zc;
    logic signed [Z_W:0]  f_zr;
    logic signed [OW-1:0] f_q;

    always_comb begin
        f_zb = (Z_W+1)'(cd_z[CORDIC_STEPS])
             + (cd_out_side.base ? (Z_W+1)'(Z_BASE) : '0);
        if (f_zb < 0) begin
            f_zc = '0;
        end else if (f_zb > (Z_W+1)'(Z_LIM)) begin
            f_zc = (Z_W+1)'(Z_LIM);
        end else begin
            f_zc = f_zb;
        end
        f_zr = (f_zc + (Z_W+1)'(HALF)) >>> SH;
        f_q  = OW'(f_zr);
        if (cd_out_side.tag.degen) begin
            f_q = '0;
        end else if (cd_out_side.tag.neg) begin
            f_q = -f_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= cd_vld[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_tag <= cd_out_side.tag;
        r_f_q   <= f_q;
    end

    // ------------------------------------------------------------ collector
    // Pitch and yaw arrive first; the roll angle completes the word.
    logic signed [OW-1:0] r_col_pitch, r_col_yaw;
    logic [1:0]           r_col_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_f_vld && (r_f_tag.job == JOB_ROLL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_f_vld) begin
            case (r_f_tag.job)
                JOB_PITCH: begin
                    r_col_pitch   <= r_f_q;
                    r_col_mask[0] <= r_f_tag.degen;
                end
                JOB_YAW: begin
                    r_col_yaw     <= r_f_q;
                    r_col_mask[1] <= r_f_tag.degen;
                end
                JOB_ROLL: begin
                    o_pitch_error    <= r_col_pitch;
                    o_yaw_error      <= r_col_yaw;
                    o_roll_error     <= r_f_q;
                    o_undefined_mask <= {r_f_tag.degen, r_col_mask};
                end
                default: ;
            endcase
        end
    end

    // ----------------------------------------------------------- assertions
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted word did not raise busy");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((!o_undefined_mask[0] || o_pitch_error == '0)
                 && (!o_undefined_mask[1] || o_yaw_error == '0)
                 && (!o_undefined_mask[2] || o_roll_error == '0)))
        else $error("degenerate angle is not zero");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_pitch_error <= MAX_OUT && o_pitch_error >= -MAX_OUT
                 && o_yaw_error <= MAX_OUT && o_yaw_error >= -MAX_OUT
                 && o_roll_error <= MAX_OUT && o_roll_error >= -MAX_OUT))
        else $error("angle beyond 180 degrees");

endmodule
